// ===== src/fupt_pkg.sv =====
// shared types, constants and byte classifier for the font unicode table parser
package fupt_pkg;

  localparam int unsigned MapEntriesDefault = 1024;
  localparam int unsigned CodeW  = 16;
  localparam int unsigned GlyphW = 16;
  localparam int unsigned PairsW = 11;

  localparam logic [7:0] ByteSep = 8'hFF;
  localparam logic [7:0] ByteAlt = 8'hFE;

  typedef enum logic [2:0] {
    CLS_SEP,
    CLS_ALT,
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_STRAY
  } byte_class_e;

  // one queue entry: everything one byte produces, at most a pair and a summary
  typedef struct packed {
    logic              has_pair;
    logic              has_summary;
    logic [CodeW-1:0]  code_point;
    logic [GlyphW-1:0] glyph_slot;
    logic [PairsW-1:0] pairs_kept;
    logic              bad_sequence;
    logic              table_full;
  } parse_entry_t;

  function automatic byte_class_e classify(input logic [7:0] b);
    byte_class_e cls;
    if (b == ByteSep) begin
      cls = CLS_SEP;
    end else if (b == ByteAlt) begin
      cls = CLS_ALT;
    end else if (!b[7]) begin
      cls = CLS_ASCII;
    end else if (b[7:5] == 3'b110) begin
      cls = CLS_LEAD2;
    end else if (b[7:4] == 4'b1110) begin
      cls = CLS_LEAD3;
    end else begin
      cls = CLS_STRAY;
    end
    return cls;
  endfunction

endpackage

// ===== src/fupt_front.sv =====
// front end: accepts table bytes, decodes utf-8 and builds queue entries
module fupt_front #(
  parameter int unsigned MAP_ENTRIES = fupt_pkg::MapEntriesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 end_of_table_i,
  input  logic                 q_space_i,
  output logic                 q_push_o,
  output fupt_pkg::parse_entry_t q_entry_o
);

  localparam int unsigned CntW = $clog2(MAP_ENTRIES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAP_ENTRIES);

  logic [1:0]                  owed_q, owed_d;
  logic [fupt_pkg::CodeW-1:0]  partial_q, partial_d;
  logic                        skip_q, skip_d;
  logic [fupt_pkg::GlyphW-1:0] glyph_q, glyph_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic                        bad_q, bad_d;
  logic                        full_q, full_d;

  logic                        accept;
  logic                        want_pair;
  logic [fupt_pkg::CodeW-1:0]  pair_cp;
  logic                        has_pair;
  fupt_pkg::byte_class_e       cls;

  assign in_ready_o = q_space_i;
  assign accept     = in_valid_i & in_ready_o;
  assign cls        = fupt_pkg::classify(data_byte_i);

  always_comb begin
    owed_d    = owed_q;
    partial_d = partial_q;
    skip_d    = skip_q;
    glyph_d   = glyph_q;
    cnt_d     = cnt_q;
    bad_d     = bad_q;
    full_d    = full_q;
    want_pair = 1'b0;
    pair_cp   = '0;
    has_pair  = 1'b0;

    if (owed_q == 2'd1) begin
      pair_cp   = partial_q | {10'd0, data_byte_i[5:0]};
      want_pair = 1'b1;
      owed_d    = 2'd0;
      partial_d = '0;
    end else if (owed_q == 2'd2 && !end_of_table_i) begin
      partial_d = partial_q | {4'd0, data_byte_i[5:0], 6'd0};
      owed_d    = 2'd1;
    end else begin
      // truncated three-byte sequence: drop it and treat the byte as fresh
      if (owed_q == 2'd2) begin
        bad_d     = 1'b1;
        owed_d    = 2'd0;
        partial_d = '0;
      end
      if (skip_q) begin
        if (cls == fupt_pkg::CLS_SEP) begin
          skip_d  = 1'b0;
          glyph_d = glyph_q + 1'b1;
        end
      end else begin
        unique case (cls)
          fupt_pkg::CLS_SEP:   glyph_d = glyph_q + 1'b1;
          fupt_pkg::CLS_ALT:   skip_d = 1'b1;
          fupt_pkg::CLS_ASCII: begin
            want_pair = 1'b1;
            pair_cp   = {8'd0, data_byte_i};
          end
          fupt_pkg::CLS_LEAD2: begin
            if (end_of_table_i) begin
              bad_d = 1'b1;
            end else begin
              owed_d    = 2'd1;
              partial_d = {5'd0, data_byte_i[4:0], 6'd0};
            end
          end
          fupt_pkg::CLS_LEAD3: begin
            if (end_of_table_i) begin
              bad_d = 1'b1;
            end else begin
              owed_d    = 2'd2;
              partial_d = {data_byte_i[3:0], 12'd0};
            end
          end
          default: bad_d = 1'b1;
        endcase
      end
    end

    if (want_pair) begin
      if (cnt_q < CntMax) begin
        cnt_d    = cnt_q + 1'b1;
        has_pair = 1'b1;
      end else begin
        full_d = 1'b1;
      end
    end

    if (end_of_table_i) begin
      owed_d    = 2'd0;
      partial_d = '0;
      skip_d    = 1'b0;
    end
  end

  // glyph counter does not move on a byte that emits a pair, so one slot serves both results
  assign q_entry_o.has_pair     = has_pair;
  assign q_entry_o.has_summary  = end_of_table_i;
  assign q_entry_o.code_point   = pair_cp;
  assign q_entry_o.glyph_slot   = glyph_d;
  assign q_entry_o.pairs_kept   = fupt_pkg::PairsW'(cnt_d);
  assign q_entry_o.bad_sequence = bad_d;
  assign q_entry_o.table_full   = full_d;
  assign q_push_o = accept & (has_pair | end_of_table_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q    <= '0;
      partial_q <= '0;
      skip_q    <= 1'b0;
      glyph_q   <= '0;
      cnt_q     <= '0;
      bad_q     <= 1'b0;
      full_q    <= 1'b0;
    end else if (accept) begin
      owed_q    <= owed_d;
      partial_q <= partial_d;
      skip_q    <= skip_d;
      glyph_q   <= glyph_d;
      cnt_q     <= cnt_d;
      bad_q     <= bad_d;
      full_q    <= full_d;
    end
  end

endmodule

// ===== src/fupt_queue.sv =====
// two-entry queue between the decode front end and the result back end
module fupt_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  fupt_pkg::parse_entry_t push_entry_i,
  output logic                   space_o,
  input  logic                   pop_i,
  output logic                   valid_o,
  output fupt_pkg::parse_entry_t head_o
);

  fupt_pkg::parse_entry_t slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign space_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== src/fupt_back.sv =====
// back end: turns queue entries into one or two result beats
module fupt_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  fupt_pkg::parse_entry_t      q_head_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        kind_o,
  output logic [fupt_pkg::CodeW-1:0]  code_point_o,
  output logic [fupt_pkg::GlyphW-1:0] glyph_slot_o,
  output logic [fupt_pkg::PairsW-1:0] pairs_kept_o,
  output logic                        bad_sequence_o,
  output logic                        table_full_o,
  output logic                        run_end_o
);

  fupt_pkg::parse_entry_t cur_q;
  logic cur_valid_q;
  logic pair_left_q;
  logic last_beat;
  logic load;

  assign last_beat = !(pair_left_q && cur_q.has_summary);
  assign load      = q_valid_i && (!cur_valid_q || (out_ready_i && last_beat));
  assign q_pop_o   = load;

  assign out_valid_o    = cur_valid_q;
  assign kind_o         = !pair_left_q;
  assign code_point_o   = pair_left_q ? cur_q.code_point : '0;
  assign glyph_slot_o   = cur_q.glyph_slot;
  assign pairs_kept_o   = cur_q.pairs_kept;
  assign bad_sequence_o = cur_q.bad_sequence;
  assign table_full_o   = cur_q.table_full;
  assign run_end_o      = last_beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      pair_left_q <= 1'b0;
    end else if (load) begin
      cur_valid_q <= 1'b1;
      pair_left_q <= q_head_i.has_pair;
    end else if (cur_valid_q && out_ready_i) begin
      // pair beat went out, the summary follows
      if (!last_beat) begin
        pair_left_q <= 1'b0;
      end else begin
        cur_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= q_head_i;
    end
  end

endmodule

// ===== src/font_unicode_table_parser_top.sv =====
// top level of the font unicode table parser
//
//  channel | direction | handshake               | beat
//  in      | input     | in_valid_i / in_ready_o | data_byte_i, end_of_table_i
//  out     | output    | out_valid_o/out_ready_i | kind_o .. run_end_o
//
// one byte per cycle enters while in_ready_o is high; decode is combinational
// in the accepting cycle, the entry is then registered in the queue and loaded
// into the back end output register, from which its result beats are taken
// a byte with a pair and a summary needs two output beats, so the out side
// sets the sustained rate when many such bytes come in a row
// the two-entry queue lets the front keep taking bytes while out stalls;
// in_ready_o drops while the queue holds two entries
// reset clears decode state, counters, flags and the queue
module font_unicode_table_parser_top #(
  parameter int unsigned MAP_ENTRIES = fupt_pkg::MapEntriesDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        end_of_table_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        kind_o,
  output logic [fupt_pkg::CodeW-1:0]  code_point_o,
  output logic [fupt_pkg::GlyphW-1:0] glyph_slot_o,
  output logic [fupt_pkg::PairsW-1:0] pairs_kept_o,
  output logic                        bad_sequence_o,
  output logic                        table_full_o,
  output logic                        run_end_o
);

  fupt_pkg::parse_entry_t push_entry;
  fupt_pkg::parse_entry_t head_entry;
  logic push;
  logic space;
  logic pop;
  logic head_valid;

  fupt_front #(
    .MAP_ENTRIES(MAP_ENTRIES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .end_of_table_i(end_of_table_i),
    .q_space_i     (space),
    .q_push_o      (push),
    .q_entry_o     (push_entry)
  );

  fupt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .space_o     (space),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .head_o      (head_entry)
  );

  fupt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (head_valid),
    .q_head_i      (head_entry),
    .q_pop_o       (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .code_point_o  (code_point_o),
    .glyph_slot_o  (glyph_slot_o),
    .pairs_kept_o  (pairs_kept_o),
    .bad_sequence_o(bad_sequence_o),
    .table_full_o  (table_full_o),
    .run_end_o     (run_end_o)
  );

endmodule
